>>> src/sync_sequence_correlator_detector_core_assert.svh
// Assertion macros for the sync sequence correlator.
`ifndef SYNC_SEQUENCE_CORRELATOR_DETECTOR_CORE_ASSERT_SVH
`define SYNC_SEQUENCE_CORRELATOR_DETECTOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SSCD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SSCD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SSCD_ASSERT_IMP(label, ante, cons)
`define SSCD_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> src/sscd_pkg.sv
// Shared types and constants for the sync sequence correlator.
package sscd_pkg;
  localparam int TAPS = 128;
  localparam int SW = 16;
  localparam int IDXW = $clog2(TAPS);
  localparam int ACCW = 48;
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [23:0] THRESHOLD_RESET = 24'd7000;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_SCAN = 4'b0010, ST_SQRT = 4'b0100, ST_OUT = 4'b1000
  } state_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic rotate;
    logic clear;
  } cell_ctl_t;
endpackage

>>> src/sync_sequence_correlator_detector_core.sv
// Top level: cell chain, shared complex MAC, bit-serial square root, detector.
// A sample transfer starts the scan: the ring rotates past cell 0 while the MAC sums the
// registered products, then the square root runs bit by bit and out_tvalid is raised.
// The single MAC walks the ring and the result drains before the next transfer is accepted;
// a new sample waits until out_tready takes the result. Loads, restarts: only in ST_IDLE.
// Reset (rst_n, synchronous): window and count cleared, threshold 7000; taps undefined.
`include "sync_sequence_correlator_detector_core_assert.svh"
module sync_sequence_correlator_detector_core import sscd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[1:0], tap_index[8:2], tap_re[24:9], tap_im[40:25],
  // sample_re[56:41], sample_im[72:57], zero fill
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // corr_re[23:0], corr_im[47:24], magnitude[71:48], above_threshold[72],
  // exceed_count[104:73], zero fill
  output logic [111:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);
  state_t state_r, state_nxt;
  logic [23:0] thr_r;
  logic [IDXW:0] cnt_r;
  logic signed [ACCW-1:0] acc_re_r, acc_im_r;
  logic signed [33:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic pv_r;
  logic [47:0] rad_r;
  logic [23:0] root_r;
  logic [25:0] rem_r;
  logic [4:0] sq_r;
  logic signed [23:0] cr_r, ci_r;
  logic [31:0] count_r;
  logic [111:0] out_data_r;
  logic out_valid_r;

  logic [1:0] opcode;
  logic [6:0] tap_index;
  logic signed [15:0] tap_re, tap_im;
  logic signed [SW-1:0] smp_re, smp_im;
  assign opcode = in_tdata[1:0];
  assign tap_index = in_tdata[8:2];
  assign tap_re = in_tdata[24:9];
  assign tap_im = in_tdata[40:25];
  assign smp_re = in_tdata[41 +: SW];
  assign smp_im = in_tdata[57 +: SW];

  logic in_xfer;
  assign in_tready = state_r == ST_IDLE;
  assign in_xfer = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // cell ring
  cell_ctl_t ctl;
  logic signed [SW-1:0] s_re [TAPS], s_im [TAPS];
  logic signed [15:0] t_re [TAPS], t_im [TAPS];
  assign ctl.shift = in_xfer && opcode == OP_SAMPLE;
  assign ctl.rotate = state_r == ST_SCAN && cnt_r < (IDXW+1)'(TAPS);
  assign ctl.clear = in_xfer && opcode == OP_RESTART;

  for (genvar g = 0; g < TAPS; g++) begin : g_cell
    logic signed [SW-1:0] sri, sii;
    logic signed [15:0] tri_, tii;
    if (g == TAPS-1) begin : g_head
      assign sri = ctl.shift ? smp_re : s_re[0];
      assign sii = ctl.shift ? smp_im : s_im[0];
    end else begin : g_body
      assign sri = s_re[g+1];
      assign sii = s_im[g+1];
    end
    assign tri_ = t_re[(g+1) % TAPS];
    assign tii = t_im[(g+1) % TAPS];
    sscd_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .tap_we(in_xfer && opcode == OP_LOAD && tap_index == IDXW'(g)),
      .tap_re_in(tap_re), .tap_im_in(tap_im),
      .s_re_in(sri), .s_im_in(sii), .t_re_in(tri_), .t_im_in(tii),
      .s_re(s_re[g]), .s_im(s_im[g]), .t_re(t_re[g]), .t_im(t_im[g])
    );
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (ctl.shift) state_nxt = ST_SCAN;
      ST_SCAN: if (cnt_r == (IDXW+1)'(TAPS) && !pv_r) state_nxt = ST_SQRT;
      ST_SQRT: if (sq_r == 5'd25) state_nxt = ST_OUT;
      ST_OUT: if (!out_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= THRESHOLD_RESET;
    else if (cfg_valid && cfg_ready) thr_r <= cfg_data;
  end

  // products of cell 0 (oldest sample, tap 0 after full rotation count)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      pv_r <= ctl.rotate;
      if (ctl.shift) cnt_r <= '0;
      else if (ctl.rotate) cnt_r <= cnt_r + 1'b1;
    end
    p_rr_r <= 34'(s_re[0] * t_re[0]);
    p_ii_r <= 34'(s_im[0] * t_im[0]);
    p_ri_r <= 34'(s_re[0] * t_im[0]);
    p_ir_r <= 34'(s_im[0] * t_re[0]);
  end

  // accumulate
  logic signed [ACCW-1:0] sh_re, sh_im;
  logic signed [23:0] sat_re, sat_im;
  assign sh_re = acc_re_r >>> 15;
  assign sh_im = acc_im_r >>> 15;
  assign sat_re = (sh_re > 48'sd8388607) ? 24'sh7FFFFF :
                  (sh_re < -48'sd8388608) ? 24'sh800000 : sh_re[23:0];
  assign sat_im = (sh_im > 48'sd8388607) ? 24'sh7FFFFF :
                  (sh_im < -48'sd8388608) ? 24'sh800000 : sh_im[23:0];

  logic [47:0] sq_sum;
  logic signed [47:0] cr2, ci2;
  assign cr2 = 48'(cr_r * cr_r);
  assign ci2 = 48'(ci_r * ci_r);
  assign sq_sum = 48'(cr2) + 48'(ci2);

  // restoring square root, one bit a cycle; all 24 bits are done when sq_r is 25
  logic [25:0] trial;
  logic [25:0] rem_sh;
  assign rem_sh = {rem_r[23:0], rad_r[47:46]};
  assign trial = {root_r, 2'b01};

  logic hit;
  assign hit = root_r > thr_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (pv_r) begin
      acc_re_r <= acc_re_r + ACCW'(p_rr_r) - ACCW'(p_ii_r);
      acc_im_r <= acc_im_r + ACCW'(p_ri_r) + ACCW'(p_ir_r);
    end
    if (state_r == ST_SCAN && state_nxt == ST_SQRT) begin
      cr_r <= sat_re;
      ci_r <= sat_im;
      sq_r <= '0;
      root_r <= '0;
      rem_r <= '0;
      rad_r <= '0;
    end else if (state_r == ST_SQRT) begin
      if (sq_r == 5'd0 && rad_r == '0 && root_r == '0 && rem_r == '0)
        rad_r <= sq_sum;
      sq_r <= sq_r + 1'b1;
      if (sq_r != 5'd0) begin
        rad_r <= {rad_r[45:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r <= rem_sh - trial;
          root_r <= {root_r[22:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          root_r <= {root_r[22:0], 1'b0};
        end
      end
    end
  end

  // count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.clear) count_r <= '0;
      else if (state_r == ST_SQRT && sq_r == 5'd25 && hit && count_r != '1)
        count_r <= count_r + 1'b1;
      if (state_r == ST_SQRT && sq_r == 5'd25) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
    if (state_r == ST_SQRT && sq_r == 5'd25)
      out_data_r <= {7'd0, (hit && count_r != '1) ? count_r + 1'b1 : count_r,
                     hit, root_r, ci_r, cr_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  `SSCD_ASSERT_IMP(a_onehot, 1'b1, $onehot(state_r))
  `SSCD_ASSERT_IMP(a_no_accept_busy, state_r != ST_IDLE, !in_tready)
  `SSCD_ASSERT_NXT(a_out_hold, out_valid_r && !out_tready, out_valid_r)
endmodule

>>> src/sscd_cell.sv
// One window cell: holds a sample and a tap, passes both to its neighbor.
module sscd_cell import sscd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cell_ctl_t              ctl,
  input  logic                   tap_we,
  input  logic signed [15:0]     tap_re_in,
  input  logic signed [15:0]     tap_im_in,
  input  logic signed [SW-1:0]   s_re_in,
  input  logic signed [SW-1:0]   s_im_in,
  input  logic signed [15:0]     t_re_in,
  input  logic signed [15:0]     t_im_in,
  output logic signed [SW-1:0]   s_re,
  output logic signed [SW-1:0]   s_im,
  output logic signed [15:0]     t_re,
  output logic signed [15:0]     t_im
);
  logic signed [SW-1:0] s_re_r, s_im_r;
  logic signed [15:0] t_re_r, t_im_r;

  // sample slot: shift or rotate, cleared by restart
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      s_re_r <= '0;
      s_im_r <= '0;
    end else if (ctl.shift || ctl.rotate) begin
      s_re_r <= s_re_in;
      s_im_r <= s_im_in;
    end
  end

  // tap slot: rotates with the sample, written by a load
  always_ff @(posedge clk) begin
    if (tap_we) begin
      t_re_r <= tap_re_in;
      t_im_r <= tap_im_in;
    end else if (ctl.rotate) begin
      t_re_r <= t_re_in;
      t_im_r <= t_im_in;
    end
  end

  assign s_re = s_re_r;
  assign s_im = s_im_r;
  assign t_re = t_re_r;
  assign t_im = t_im_r;
endmodule

>>> tb/sv/sync_sequence_correlator_detector_core_tb.sv
// Self-checking testbench for the sync sequence correlator and detector core.
module sync_sequence_correlator_detector_core_tb;
  import sscd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NTAPS = 128;
  localparam int SETTLE_CYCLES = 220;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int HOLD_CYCLES = 2500;

  typedef struct {
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic [23:0]        mag;
    logic               hit;
    logic [31:0]        cnt;
  } corr_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [79:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [23:0]  cfg_data = '0;

  sync_sequence_correlator_detector_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  int signed    win_re[NTAPS];
  int signed    win_im[NTAPS];
  int signed    coef_re[NTAPS];
  int signed    coef_im[NTAPS];
  logic [31:0]  hit_count;
  logic [23:0]  thresh;
  corr_result_t pending_corr[$];

  int errors = 0;
  int mismatches = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int items_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_gen = 0;
  int quiet_cycles = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [23:0] floor_sqrt(longint unsigned n);
    longint unsigned r;
    r = 0;
    for (int k = 24; k >= 0; k--) begin
      if ((r | (64'd1 << k)) * (r | (64'd1 << k)) <= n) r = r | (64'd1 << k);
    end
    return r[23:0];
  endfunction

  function automatic longint signed clamp24(longint signed v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // update the model for one accepted transfer, queue a result for samples
  task automatic correlate_item(logic [79:0] d);
    logic [1:0]      op;
    logic [6:0]      idx;
    longint signed   acc_re, acc_im, cr, ci;
    corr_result_t    r;
    op  = d[1:0];
    idx = d[8:2];
    acc_re = 0;
    acc_im = 0;
    case (op)
      OP_LOAD: begin
        coef_re[idx] = $signed(d[24:9]);
        coef_im[idx] = $signed(d[40:25]);
      end
      OP_RESTART: begin
        foreach (win_re[j]) begin
          win_re[j] = 0;
          win_im[j] = 0;
        end
        hit_count = '0;
      end
      OP_SAMPLE: begin
        for (int j = 0; j < NTAPS - 1; j++) begin
          win_re[j] = win_re[j+1];
          win_im[j] = win_im[j+1];
        end
        win_re[NTAPS-1] = $signed(d[56:41]);
        win_im[NTAPS-1] = $signed(d[72:57]);
        for (int j = 0; j < NTAPS; j++) begin
          acc_re += longint'(win_re[j]) * coef_re[j] - longint'(win_im[j]) * coef_im[j];
          acc_im += longint'(win_re[j]) * coef_im[j] + longint'(win_im[j]) * coef_re[j];
        end
        // arithmetic shift floors toward minus infinity
        cr = clamp24(acc_re >>> 15);
        ci = clamp24(acc_im >>> 15);
        r.re  = cr[23:0];
        r.im  = ci[23:0];
        r.mag = floor_sqrt(longint'(cr * cr + ci * ci));
        r.hit = r.mag > thresh;
        if (r.hit && hit_count != 32'hFFFF_FFFF) hit_count = hit_count + 1;
        r.cnt = hit_count;
        pending_corr.insert(pending_corr.size(), r);
      end
      default: ;
    endcase
  endtask

  // one input transfer, with random sender gaps
  task automatic send_item(logic [1:0] op, logic [6:0] idx, logic [15:0] tr,
                           logic [15:0] ti, logic [15:0] sr, logic [15:0] si);
    logic [79:0] d;
    d = {7'd0, si, sr, ti, tr, idx, op};
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    correlate_item(d);
    items_sent++;
  endtask

  task automatic send_sample(logic [15:0] sr, logic [15:0] si);
    send_item(OP_SAMPLE, 7'($urandom), 16'($urandom), 16'($urandom), sr, si);
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  // stop offering and wait for every result, then for in-flight work
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_corr.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [23:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thresh = v;
  endtask

  // result check
  always @(posedge clk) begin
    corr_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tdata[72]) hits_seen++;
      if (pending_corr.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", out_tdata);
      end else begin
        e = pending_corr.pop_front();
        if (out_tdata[23:0] !== e.re || out_tdata[47:24] !== e.im ||
            out_tdata[71:48] !== e.mag || out_tdata[72] !== e.hit ||
            out_tdata[104:73] !== e.cnt) begin
          errors++;
          if (mismatches++ < 10) begin
            $display("mismatch: exp re=%0d im=%0d mag=%0d hit=%0b cnt=%0d",
                     e.re, e.im, e.mag, e.hit, e.cnt);
            $display("          got re=%0d im=%0d mag=%0d hit=%0b cnt=%0d",
                     $signed(out_tdata[23:0]), $signed(out_tdata[47:24]),
                     out_tdata[71:48], out_tdata[72], out_tdata[104:73]);
          end
        end
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    static int hold_left = 0;
    static int hold_seen = 0;
    if (hold_seen != hold_gen) begin
      hold_seen = hold_gen;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_load_taps();
    for (int i = 0; i < NTAPS; i++)
      send_item(OP_LOAD, 7'(i), rand_value(), rand_value(), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h0000, 16'h0000);
    // unused opcode leaves state alone
    send_item(OP_UNUSED, 7'h7F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'h0001, 16'hFFFF);
    // strongest taps at indices 127 and 0, then full-scale samples
    send_item(OP_LOAD, 7'd127, 16'h7FFF, 16'h8000, 16'h0, 16'h0);
    send_item(OP_LOAD, 7'd0, 16'h8000, 16'h7FFF, 16'h0, 16'h0);
    for (int i = 0; i < 6; i++) send_sample(16'h8000, 16'h7FFF);
    // restart clears window and count
    send_item(OP_RESTART, 7'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h1234, 16'hEDCB);
    // zero samples to start flushing the window
    for (int i = 0; i < 4; i++) send_sample(16'h0000, 16'h0000);
    drain();
  endtask

  task automatic test_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 86) send_sample(rand_value(), rand_value());
      else if (k < 94)
        send_item(OP_LOAD, 7'($urandom), rand_value(), rand_value(),
                  16'($urandom), 16'($urandom));
      else if (k < 97) send_item(OP_RESTART, 7'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom));
      else send_item(OP_UNUSED, 7'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
    end
    drain();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_gen++;
    for (int i = 0; i < 24; i++) send_sample(rand_value(), rand_value());
    drain();
  endtask

  initial begin
    foreach (win_re[j]) begin
      win_re[j] = 0;
      win_im[j] = 0;
      coef_re[j] = 0;
      coef_im[j] = 0;
    end
    hit_count = '0;
    thresh = THRESHOLD_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_taps();
    test_directed();
    write_threshold(24'd0);
    test_random(250);
    idle_pct = 68;
    write_threshold(24'hFFFFFF);
    test_random(200);
    idle_pct = 0;
    stall_pct = 68;
    write_threshold(24'($urandom_range(20000, 1000)));
    test_random(300);
    idle_pct = 25;
    stall_pct = 25;
    write_threshold(24'($urandom_range(200000)));
    test_random(300);
    test_backpressure();
    idle_pct = 10;
    stall_pct = 10;
    write_threshold(THRESHOLD_RESET);
    test_random(150);

    $display("Covered %0d transfers in: tap loads, restarts, unused opcode, five thresholds",
             items_sent);
    $display("and four idle/stall mixes plus a long hold-off; %0d results, %0d detections.",
             results_seen, hits_seen);
    if (errors == 0 && pending_corr.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
